FILE: sv/rounded_rect_span_generator_assert.svh
// assertion macros for the rounded rectangle span generator
// used by the module that checks its own logic, needs i_clk and i_rst_n in scope
`ifndef ROUNDED_RECT_SPAN_GENERATOR_ASSERT_SVH
`define ROUNDED_RECT_SPAN_GENERATOR_ASSERT_SVH

// checked only out of reset
`define RRSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RRSG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/rrsg_pkg.sv
// shared widths, defaults and controller/datapath interface types
// no dependencies
package rrsg_pkg;

    localparam int COORD_W        = 16;
    localparam int MAX_RADIUS_DEF = 15;

    typedef struct packed {
        logic load;
        logic step_a;
        logic step_b;
        logic next_pair;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic adv;
        logic out_free;
        logic pair_live;
        logic top_pair;
    } t_status;

endpackage

FILE: sv/rrsg_ctrl.sv
// sequencer for the rounded rectangle span generator
// depends on rrsg_pkg, drives the datapath by t_cmd and reads t_status
module rrsg_ctrl import rrsg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_STEP_A = 2'd1;
    localparam logic [1:0] S_STEP_B = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_STEP_A;
                end
            end
            S_STEP_A: begin
                if (i_status.adv) begin
                    if (i_status.pair_live) begin
                        o_cmd.step_a = 1'b1;
                        n_state      = S_STEP_B;
                    end else if (!i_status.top_pair) begin
                        o_cmd.next_pair = 1'b1;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_STEP_B: begin
                if (i_status.adv) begin
                    o_cmd.step_b = 1'b1;
                    n_state      = S_STEP_A;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: sv/rrsg_datapath.sv
// midpoint stepping registers, pending window and output register
// depends on rrsg_pkg and rounded_rect_span_generator_assert.svh
`include "rounded_rect_span_generator_assert.svh"
module rrsg_datapath import rrsg_pkg::*; #(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [COORD_W-1:0] i_rect_x,
    input  logic [COORD_W-1:0] i_rect_y,
    input  logic [COORD_W-1:0] i_rect_width,
    input  logic [COORD_W-1:0] i_rect_height,
    input  logic [COORD_W-1:0] i_corner_radius,
    input  logic [COORD_W-1:0] i_fill_color,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [COORD_W-1:0] o_win_x_start,
    output logic [COORD_W-1:0] o_win_y_start,
    output logic [COORD_W-1:0] o_win_x_end,
    output logic [COORD_W-1:0] o_win_y_end,
    output logic [COORD_W-1:0] o_span_color,
    output logic               o_last_span
);

    localparam int R_W = $clog2(MAX_RADIUS + 1);
    localparam int F_W = R_W + 3;
    localparam logic [R_W-1:0] RAD_MAX = R_W'(MAX_RADIUS);

    logic [R_W-1:0]        rad;
    logic [COORD_W-1:0]    rad16;
    logic [R_W-1:0]        r_rad;
    logic [R_W-1:0]        r_yy;
    logic [R_W-1:0]        r_rr;
    logic signed [F_W-1:0] r_f;
    logic signed [F_W-1:0] r_ddx;
    logic signed [F_W-1:0] r_ddy;
    logic                  r_top;
    logic [COORD_W-1:0]    r_cx;
    logic [COORD_W-1:0]    r_cy_bot;
    logic [COORD_W-1:0]    r_cy_top;
    logic [COORD_W-1:0]    r_span0;
    logic [COORD_W-1:0]    r_color;

    logic                  r_pend_v;
    logic [COORD_W-1:0]    r_pend_xs;
    logic [COORD_W-1:0]    r_pend_ys;
    logic [COORD_W-1:0]    r_pend_xe;
    logic [COORD_W-1:0]    r_pend_ye;

    logic                  r_out_valid;
    logic [COORD_W-1:0]    r_out_xs;
    logic [COORD_W-1:0]    r_out_ys;
    logic [COORD_W-1:0]    r_out_xe;
    logic [COORD_W-1:0]    r_out_ye;
    logic [COORD_W-1:0]    r_out_color;
    logic                  r_out_last;

    logic [R_W-1:0]        yy_next;
    logic [COORD_W-1:0]    yy16;
    logic [COORD_W-1:0]    yy1_16;
    logic [COORD_W-1:0]    rr16;
    logic                  f_pos;
    logic                  cand_v;
    logic [COORD_W-1:0]    cand_xs;
    logic [COORD_W-1:0]    cand_len;
    logic [COORD_W-1:0]    cand_row;
    logic                  push;
    logic                  out_free;

    assign rad    = (i_corner_radius > COORD_W'(MAX_RADIUS)) ? RAD_MAX
                                                              : i_corner_radius[R_W-1:0];
    assign rad16  = {{(COORD_W-R_W){1'b0}}, rad};
    assign yy_next = r_yy + R_W'(1);
    assign yy16   = {{(COORD_W-R_W){1'b0}}, r_yy};
    assign yy1_16 = {{(COORD_W-R_W){1'b0}}, yy_next};
    assign rr16   = {{(COORD_W-R_W){1'b0}}, r_rr};
    assign f_pos  = !r_f[F_W-1];

    always_comb begin
        cand_v   = 1'b0;
        cand_xs  = r_cx - yy16;
        cand_len = r_span0 + (yy16 << 1);
        cand_row = r_top ? (r_cy_top - rr16) : (r_cy_bot + rr16);
        if (i_cmd.step_a) begin
            cand_v = f_pos;
        end else if (i_cmd.step_b) begin
            cand_v   = 1'b1;
            cand_xs  = r_cx - rr16;
            cand_len = r_span0 + (rr16 << 1);
            cand_row = r_top ? (r_cy_top - yy1_16) : (r_cy_bot + yy1_16);
        end
    end

    assign push     = cand_v && (cand_len != '0) && r_pend_v;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.adv       = !r_pend_v || out_free;
    assign o_status.out_free  = out_free;
    assign o_status.pair_live = (r_yy < r_rr);
    assign o_status.top_pair  = r_top;

    // stepping state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.next_pair) begin
            r_yy  <= '0;
            r_rr  <= i_cmd.load ? rad : r_rad;
            r_f   <= F_W'(1) - $signed({1'b0, i_cmd.load ? rad : r_rad});
            r_ddx <= F_W'(1);
            r_ddy <= -($signed({1'b0, i_cmd.load ? rad : r_rad}) <<< 1);
        end else if (i_cmd.step_a) begin
            if (f_pos) begin
                r_rr  <= r_rr - R_W'(1);
                r_ddy <= r_ddy + F_W'(2);
                r_f   <= r_f + r_ddy + F_W'(2);
            end
        end else if (i_cmd.step_b) begin
            r_yy  <= yy_next;
            r_ddx <= r_ddx + F_W'(2);
            r_f   <= r_f + r_ddx + F_W'(2);
        end
        if (i_cmd.load) begin
            r_rad    <= rad;
            r_cx     <= i_rect_x + rad16;
            r_cy_bot <= i_rect_y + i_rect_height - rad16 - COORD_W'(1);
            r_cy_top <= i_rect_y + rad16;
            r_span0  <= i_rect_width - (rad16 << 1);
            r_color  <= i_fill_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= 1'b0;
        end else if (i_cmd.load) begin
            r_top <= 1'b0;
        end else if (i_cmd.next_pair) begin
            r_top <= 1'b1;
        end
    end

    // pending window, held back until the next one shows whether it is the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (i_cmd.load) begin
            r_pend_v <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_v <= 1'b0;
        end
        if (i_cmd.load) begin
            r_pend_xs <= i_rect_x;
            r_pend_ys <= i_rect_y + rad16;
            r_pend_xe <= i_rect_x + i_rect_width;
            r_pend_ye <= i_rect_y + i_rect_height - rad16;
        end else if (push) begin
            r_pend_xs <= cand_xs;
            r_pend_ys <= cand_row;
            r_pend_xe <= cand_xs + cand_len - COORD_W'(1);
            r_pend_ye <= cand_row;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (push || i_cmd.flush) begin
            r_out_xs    <= r_pend_xs;
            r_out_ys    <= r_pend_ys;
            r_out_xe    <= r_pend_xe;
            r_out_ye    <= r_pend_ye;
            r_out_color <= r_color;
            r_out_last  <= i_cmd.flush;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_win_x_start = r_out_xs;
    assign o_win_y_start = r_out_ys;
    assign o_win_x_end   = r_out_xe;
    assign o_win_y_end   = r_out_ye;
    assign o_span_color  = r_out_color;
    assign o_last_span   = r_out_last;

    `RRSG_ASSERT(a_no_overwrite, !((push || i_cmd.flush) && r_out_valid && i_out_stall), "output word overwritten while stalled")
    `RRSG_ASSERT(a_flush_has_word, i_cmd.flush |-> r_pend_v, "flush with no pending window")
    `RRSG_ASSERT(a_load_empty, i_cmd.load |-> !r_pend_v, "command loaded over a pending window")
    `RRSG_ASSERT(a_flush_last, i_cmd.flush |=> (r_out_valid && r_out_last && !r_pend_v), "last word not marked")

endmodule

FILE: sv/rounded_rect_span_generator.sv
// Rounded rectangle span generator, top level.
// One command (origin, width, height, corner radius, colour) arrives on the
// input channel; the block answers with a run of fill window words: the
// central block first, then one-row spans of the bottom corner pair, then of
// the top corner pair. The final word of a command has o_last_span set.
// A word is taken at a clock edge with valid high and stall low; o_in_stall
// is high from acceptance until the last window has entered the output
// register, so the next command can be taken while that word still waits.
// Sequence: load, then the midpoint steps of each corner pair (radius r clamped
// to MAX_RADIUS), each step a pass through S_STEP_A and S_STEP_B, a close of
// each pair and the release of the last word; there are 11 midpoint steps per
// pair at r = 15. The pace is set by the single stepping unit that registers at
// most one window a cycle; output stalls can hold it.
// The first word is registered when the first non-empty corner span is
// pushed into the pending window, or by the flush when no span is pushed, as
// for a zero radius.
// When i_out_stall is high the output word holds, the stepping unit pauses
// once its one-entry pending window is full, and nothing is lost.
// Reset is synchronous, active low, and empties the output and pending stages.
// Depends on rrsg_pkg, rrsg_ctrl and rrsg_datapath.
module rounded_rect_span_generator import rrsg_pkg::*; #(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [COORD_W-1:0] i_rect_x,
    input  logic [COORD_W-1:0] i_rect_y,
    input  logic [COORD_W-1:0] i_rect_width,
    input  logic [COORD_W-1:0] i_rect_height,
    input  logic [COORD_W-1:0] i_corner_radius,
    input  logic [COORD_W-1:0] i_fill_color,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COORD_W-1:0] o_win_x_start,
    output logic [COORD_W-1:0] o_win_y_start,
    output logic [COORD_W-1:0] o_win_x_end,
    output logic [COORD_W-1:0] o_win_y_end,
    output logic [COORD_W-1:0] o_span_color,
    output logic               o_last_span
);

    t_cmd    cmd;
    t_status status;

    rrsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rrsg_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_rect_x        (i_rect_x),
        .i_rect_y        (i_rect_y),
        .i_rect_width    (i_rect_width),
        .i_rect_height   (i_rect_height),
        .i_corner_radius (i_corner_radius),
        .i_fill_color    (i_fill_color),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_win_x_start   (o_win_x_start),
        .o_win_y_start   (o_win_y_start),
        .o_win_x_end     (o_win_x_end),
        .o_win_y_end     (o_win_y_end),
        .o_span_color    (o_span_color),
        .o_last_span     (o_last_span)
    );

endmodule
